// File: rtl/utf_pkg.sv
// Shared types and helpers for the UTF-16 to UTF-8 transcoder.
// No dependencies; every other file imports this package.
`default_nettype none

package utf_pkg;

  // Queue depth between front and back parts
  localparam int unsigned QueueDepthDefault = 4;

  // Surrogate ranges (upper six bits of the code unit)
  localparam logic [5:0] HighSurPrefix = 6'b110110;
  localparam logic [5:0] LowSurPrefix  = 6'b110111;

  // Longest byte run caused by one item: held high surrogate plus one unit
  localparam int unsigned MaxBytes = 6;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_last;
    logic       string_end;
    logic       no_byte;
  } out_item_t;

  // Classified work for the back part: an optional unpaired high surrogate,
  // then an optional code point. Neither set means an end-of-string marker.
  typedef struct packed {
    logic        a_valid;
    logic [9:0]  a_bits;
    logic        b_valid;
    logic [20:0] b_code;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  // Encode one code point into 1 to 4 UTF-8 bytes, byte 0 first
  function automatic enc_t encode(input logic [20:0] code);
    enc_t e;
    e.bytes = '0;
    if (code[20:7] == 14'd0) begin
      e.len      = 3'd1;
      e.bytes[0] = {1'b0, code[6:0]};
    end else if (code[20:11] == 10'd0) begin
      e.len      = 3'd2;
      e.bytes[0] = {3'b110, code[10:6]};
      e.bytes[1] = {2'b10, code[5:0]};
    end else if (code[20:16] == 5'd0) begin
      e.len      = 3'd3;
      e.bytes[0] = {4'b1110, code[15:12]};
      e.bytes[1] = {2'b10, code[11:6]};
      e.bytes[2] = {2'b10, code[5:0]};
    end else begin
      e.len      = 3'd4;
      e.bytes[0] = {5'b11110, code[20:18]};
      e.bytes[1] = {2'b10, code[17:12]};
      e.bytes[2] = {2'b10, code[11:6]};
      e.bytes[3] = {2'b10, code[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/utf_front.sv
// Front part: accepts code units, pairs surrogates, tracks string end.
// Depends on utf_pkg; feeds classified jobs into utf_queue.
`default_nettype none

module utf_front import utf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t up_item,
  input  wire logic     up_valid,
  output logic          up_ready,
  output job_t          job,
  output logic          job_valid,
  input  wire logic     job_ready
);

  logic       high_pending;
  logic [9:0] high_bits;
  logic       terminated;

  logic       high_pending_next;
  logic [9:0] high_bits_next;
  logic       terminated_next;

  logic       accept;
  logic       is_low;
  logic       is_high;
  logic       pair;

  assign up_ready = job_ready;
  assign accept   = up_valid && up_ready;

  assign is_low  = (up_item.code_unit[15:10] == LowSurPrefix);
  assign is_high = (up_item.code_unit[15:10] == HighSurPrefix);
  assign pair    = high_pending && is_low;

  // Classify the unit against the held state
  always_comb begin
    job                = '0;
    job.last           = up_item.last_unit;
    high_pending_next  = high_pending;
    high_bits_next     = high_bits;
    terminated_next    = terminated;
    if (!terminated) begin
      job.a_valid       = high_pending && !pair;
      job.a_bits        = high_bits;
      high_pending_next = 1'b0;
      high_bits_next    = '0;
      if (pair) begin
        job.b_valid = 1'b1;
        job.b_code  = {(11'(high_bits) + 11'd64), up_item.code_unit[9:0]};
      end else if (up_item.code_unit == 16'd0) begin
        terminated_next = 1'b1;
      end else if (is_high && !up_item.last_unit) begin
        high_pending_next = 1'b1;
        high_bits_next    = up_item.code_unit[9:0];
      end else begin
        job.b_valid = 1'b1;
        job.b_code  = {5'd0, up_item.code_unit};
      end
    end
    // Last unit returns all state to reset
    if (up_item.last_unit) begin
      high_pending_next = 1'b0;
      high_bits_next    = '0;
      terminated_next   = 1'b0;
    end
  end

  // Push only units that cause results
  assign job_valid = up_valid && (job.a_valid || job.b_valid || up_item.last_unit);

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending <= 1'b0;
      high_bits    <= '0;
      terminated   <= 1'b0;
    end else if (accept) begin
      high_pending <= high_pending_next;
      high_bits    <= high_bits_next;
      terminated   <= terminated_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/utf_queue.sv
// Small job queue that decouples the front and back parts.
// Depends on utf_pkg for the job type.
`default_nettype none

module utf_queue import utf_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t wr_job,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output job_t      rd_job,
  output logic      rd_valid,
  input  wire logic rd_ready
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != Full);
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/utf_back.sv
// Back part: expands a job into UTF-8 bytes, one item per cycle while the output is not stalled.
// Depends on utf_pkg; drains utf_queue and drives the output register.
`default_nettype none

module utf_back import utf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire job_t  job,
  input  wire logic  job_valid,
  output logic       job_ready,
  output out_item_t  dn_item,
  output logic       dn_valid,
  input  wire logic  dn_ready
);

  logic            cur_valid;
  logic [7:0]      cur_bytes [MaxBytes];
  logic [2:0]      cur_count;
  logic [2:0]      cur_idx;
  logic            cur_last;
  logic            cur_marker;

  logic [7:0]      load_bytes [MaxBytes];
  logic [2:0]      load_count;
  enc_t            enc_a;
  enc_t            enc_b;
  logic            emit;
  logic            fin;
  logic            load;

  assign emit      = cur_valid && (!dn_valid || dn_ready);
  assign fin       = emit && (cur_idx == cur_count - 3'd1);
  assign load      = job_valid && (!cur_valid || fin);
  assign job_ready = !cur_valid || fin;

  assign enc_a = encode({5'd0, HighSurPrefix, job.a_bits});
  assign enc_b = encode(job.b_code);

  // Lay out the byte run of the queue head
  always_comb begin
    for (int i = 0; i < MaxBytes; i++) begin
      load_bytes[i] = '0;
    end
    if (job.a_valid) begin
      for (int i = 0; i < 3; i++) begin
        load_bytes[i]     = enc_a.bytes[i];
        load_bytes[i + 3] = enc_b.bytes[i];
      end
      load_count = job.b_valid ? (3'd3 + enc_b.len) : 3'd3;
    end else if (job.b_valid) begin
      for (int i = 0; i < 4; i++) begin
        load_bytes[i] = enc_b.bytes[i];
      end
      load_count = enc_b.len;
    end else begin
      load_count = 3'd1;
    end
  end

  // Hold the current job and step through its bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_idx   <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      cur_idx   <= '0;
    end else if (fin) begin
      cur_valid <= 1'b0;
      cur_idx   <= '0;
    end else if (emit) begin
      cur_idx <= cur_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_bytes  <= load_bytes;
      cur_count  <= load_count;
      cur_last   <= job.last;
      cur_marker <= !job.a_valid && !job.b_valid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (emit) begin
      dn_valid <= 1'b1;
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dn_item.utf8_byte  <= cur_marker ? 8'd0 : cur_bytes[cur_idx];
      dn_item.run_last   <= (cur_idx == cur_count - 3'd1);
      dn_item.string_end <= (cur_idx == cur_count - 3'd1) && cur_last;
      dn_item.no_byte    <= cur_marker;
    end
  end

endmodule

`default_nettype wire

// File: rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder, top level: front, job queue, back.
// Path: job queue, then the back part's job register, then the output register.
// Throughput: one byte per cycle at the output register while dn_ready allows; a unit
// yields 0 to 6 bytes, and a last unit that yields none gives one marker item.
// Reset: synchronous active-high rst clears surrogate, string and queue state.
// Depends on utf_pkg, utf_front, utf_queue, utf_back.
`default_nettype none

module utf16_to_utf8_transcoder import utf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t up_item,
  input  wire logic     up_valid,
  output logic          up_ready,
  output out_item_t     dn_item,
  output logic          dn_valid,
  input  wire logic     dn_ready
);

  job_t f_job;
  logic f_valid;
  logic f_ready;
  job_t b_job;
  logic b_valid;
  logic b_ready;

  utf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .up_item   (up_item),
    .up_valid  (up_valid),
    .up_ready  (up_ready),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  utf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (f_job),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_job   (b_job),
    .rd_valid (b_valid),
    .rd_ready (b_ready)
  );

  utf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (b_job),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .dn_item   (dn_item),
    .dn_valid  (dn_valid),
    .dn_ready  (dn_ready)
  );

endmodule

`default_nettype wire

// File: rtl/utf_checker.sv
// Port-level checks on the transcoder output stream, bound to the top level.
// Depends on utf_pkg and utf16_to_utf8_transcoder.
`default_nettype none

module utf_checker import utf_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire out_item_t dn_item,
  input wire logic      dn_valid,
  input wire logic      dn_ready
);

  // A marker item carries no byte and closes both the run and the string
  a_marker: assert property (@(posedge clk) disable iff (rst)
    dn_valid && dn_item.no_byte |->
      dn_item.utf8_byte == 8'd0 && dn_item.run_last && dn_item.string_end)
    else $error("marker item malformed");

  // String end only on the last item of a run
  a_end_run: assert property (@(posedge clk) disable iff (rst)
    dn_valid && dn_item.string_end |-> dn_item.run_last)
    else $error("string end without run end");

  // A lead byte of a multibyte sequence never closes a run
  a_lead: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_item.no_byte && dn_item.utf8_byte[7:6] == 2'b11 |->
      !dn_item.run_last)
    else $error("run ends on a lead byte");

  // Stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn_item))
    else $error("stalled output item changed");

endmodule

bind utf16_to_utf8_transcoder utf_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .dn_item  (dn_item),
  .dn_valid (dn_valid),
  .dn_ready (dn_ready)
);

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for utf16_to_utf8_transcoder: directed table, then random strings.
// Predicts the UTF-8 bytes of every accepted UTF-16 unit and compares each output item.
// Depends on utf_pkg (item types) and the transcoder RTL.

module tb;
  import utf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // UTF-16 surrogate bounds
  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;

  localparam int unsigned ResetCycles  = 6;
  localparam int unsigned LongHold     = 200;
  localparam int unsigned PhaseUnits   = 112;
  localparam int unsigned MaxGap       = 30;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned ReportLimit  = 10;

  // Directed rows: typed rows carry their bytes, left-justified, first byte in [47:40]
  localparam logic Typed   = 1'b1;
  localparam logic Derived = 1'b0;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        typed;
    logic [2:0]  count;
    logic [47:0] bytes;
  } dir_row_t;

  localparam int unsigned DirCount = 25;
  localparam dir_row_t DirRows [DirCount] = '{
    '{16'h0041, 1'b0, Typed,   3'd1, 48'h41_00_00_00_00_00},
    '{16'h007F, 1'b0, Typed,   3'd1, 48'h7F_00_00_00_00_00},
    '{16'h0080, 1'b0, Typed,   3'd2, 48'hC2_80_00_00_00_00},
    '{16'h07FF, 1'b0, Typed,   3'd2, 48'hDF_BF_00_00_00_00},
    '{16'h0800, 1'b0, Typed,   3'd3, 48'hE0_A0_80_00_00_00},
    '{16'hFFFF, 1'b1, Typed,   3'd3, 48'hEF_BF_BF_00_00_00},
    '{16'h0000, 1'b1, Typed,   3'd0, 48'h0},
    '{16'hD800, 1'b0, Typed,   3'd0, 48'h0},
    '{16'hDC00, 1'b0, Typed,   3'd4, 48'hF0_90_80_80_00_00},
    '{16'hDBFF, 1'b0, Typed,   3'd0, 48'h0},
    '{16'hDFFF, 1'b1, Typed,   3'd4, 48'hF4_8F_BF_BF_00_00},
    '{16'hD83D, 1'b0, Derived, 3'd0, 48'h0},
    '{16'h0041, 1'b0, Derived, 3'd0, 48'h0},
    '{16'hDABC, 1'b1, Derived, 3'd0, 48'h0},
    '{16'hDC12, 1'b0, Derived, 3'd0, 48'h0},
    '{16'hDBFF, 1'b0, Derived, 3'd0, 48'h0},
    '{16'hD800, 1'b0, Derived, 3'd0, 48'h0},
    '{16'hFFFF, 1'b0, Derived, 3'd0, 48'h0},
    '{16'hDB00, 1'b0, Derived, 3'd0, 48'h0},
    '{16'h0000, 1'b0, Derived, 3'd0, 48'h0},
    '{16'h1234, 1'b0, Derived, 3'd0, 48'h0},
    '{16'hD800, 1'b0, Derived, 3'd0, 48'h0},
    '{16'h0041, 1'b1, Typed,   3'd0, 48'h0},
    '{16'hD800, 1'b0, Derived, 3'd0, 48'h0},
    '{16'h0000, 1'b1, Derived, 3'd0, 48'h0}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  in_item_t  up_item = '0;
  logic      up_valid = 1'b0;
  logic      up_ready;
  out_item_t dn_item;
  logic      dn_valid;
  logic      dn_ready = 1'b0;

  // Transcoder state mirrored by the predictor
  logic       high_held = 1'b0;
  logic [9:0] held_bits = '0;
  logic       string_stopped = 1'b0;

  logic [7:0]  run_bytes [$];
  out_item_t   expected_bytes [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned units_counted = 0;
  int unsigned units_sent = 0;
  int unsigned results_checked = 0;
  int unsigned markers_seen = 0;
  int unsigned failures = 0;

  utf16_to_utf8_transcoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .up_item  (up_item),
    .up_valid (up_valid),
    .up_ready (up_ready),
    .dn_item  (dn_item),
    .dn_valid (dn_valid),
    .dn_ready (dn_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Add one byte to the run of the current unit
  function automatic void add_byte(input logic [7:0] b);
    run_bytes.insert(run_bytes.size(), b);
  endfunction

  // Add one item to the tail of the expected stream
  function automatic void add_expected(input out_item_t o);
    expected_bytes.insert(expected_bytes.size(), o);
  endfunction

  // Append the UTF-8 bytes of one code point
  function automatic void append_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte(8'hC0 | 8'(cp >> 6));
      add_byte(8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      add_byte(8'hE0 | 8'(cp >> 12));
      add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      add_byte(8'h80 | 8'(cp & 21'h3F));
    end else begin
      add_byte(8'hF0 | 8'((cp >> 18) & 21'h07));
      add_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
      add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      add_byte(8'h80 | 8'(cp & 21'h3F));
    end
  endfunction

  // Advance the mirrored state by one unit and collect the bytes it releases
  function automatic void transcode_unit(input in_item_t it);
    logic [15:0] u;
    logic        handle;
    u = it.code_unit;
    handle = 1'b1;
    run_bytes.delete();
    if (!string_stopped) begin
      if (high_held) begin
        if (u >= LowFirst && u <= LowLast) begin
          append_code_point(21'h10000 + {1'b0, held_bits, 10'b0} + 21'(u - LowFirst));
          handle = 1'b0;
        end else begin
          append_code_point({5'b0, HighFirst | {6'b0, held_bits}});
        end
        high_held = 1'b0;
        held_bits = '0;
      end
      if (handle) begin
        if (u == 16'h0000) begin
          string_stopped = 1'b1;
        end else if (u >= HighFirst && u <= HighLast && !it.last_unit) begin
          high_held = 1'b1;
          held_bits = u[9:0];
        end else begin
          append_code_point({5'b0, u});
        end
      end
    end
    if (it.last_unit) begin
      high_held = 1'b0;
      held_bits = '0;
      string_stopped = 1'b0;
    end
  endfunction

  // Turn collected bytes into expected output items; an empty last unit gives a marker
  function automatic void queue_run(input logic last);
    int unsigned n;
    out_item_t   o;
    n = run_bytes.size();
    if (n == 0) begin
      if (last) begin
        o = '{utf8_byte: 8'h00, run_last: 1'b1, string_end: 1'b1, no_byte: 1'b1};
        add_expected(o);
      end
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        o.utf8_byte  = run_bytes[k];
        o.run_last   = (k == n - 1);
        o.string_end = (k == n - 1) && last;
        o.no_byte    = 1'b0;
        add_expected(o);
      end
    end
  endfunction

  function automatic int unsigned pick_gap(input int unsigned pct);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < pct) gap++;
    return gap;
  endfunction

  // Offer one unit, hold it until accepted, then predict. Entered and left at a falling edge.
  task automatic send_unit(input in_item_t it, input logic typed, input logic [2:0] count,
                           input logic [47:0] bytes);
    int unsigned gap;
    gap = pick_gap(send_idle_pct);
    if (gap != 0) begin
      up_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    up_item  <= it;
    up_valid <= 1'b1;
    do @(posedge clk); while (!up_ready);
    transcode_unit(it);
    if (typed) begin
      run_bytes.delete();
      for (int unsigned k = 0; k < count; k++) add_byte(bytes[47 - 8 * k -: 8]);
    end
    queue_run(it.last_unit);
    units_sent++;
    @(negedge clk);
  endtask

  // Build one string: mostly well-formed units and pairs, sometimes noise or broken pieces
  task automatic send_random_string();
    logic [15:0] units [$];
    int unsigned len;
    int unsigned pick;
    logic        noisy;
    in_item_t    it;
    len = $urandom_range(8, 1);
    noisy = ($urandom_range(9) == 0);
    while (units.size() < len) begin
      pick = $urandom_range(99);
      if (noisy) begin
        units.insert(units.size(), 16'($urandom_range(16'hFFFF)));
      end else if (pick < 25) begin
        units.insert(units.size(), 16'($urandom_range(16'h007F, 16'h0001)));
      end else if (pick < 40) begin
        units.insert(units.size(), 16'($urandom_range(16'h07FF, 16'h0080)));
      end else if (pick < 60) begin
        if ($urandom_range(1) == 0) begin
          units.insert(units.size(), 16'($urandom_range(16'hD7FF, 16'h0800)));
        end else begin
          units.insert(units.size(), 16'($urandom_range(16'hFFFF, 16'hE000)));
        end
      end else if (pick < 85) begin
        units.insert(units.size(), HighFirst | 16'($urandom_range(10'h3FF)));
        units.insert(units.size(), LowFirst | 16'($urandom_range(10'h3FF)));
      end else if (pick < 90) begin
        units.insert(units.size(), HighFirst | 16'($urandom_range(10'h3FF)));
      end else if (pick < 95) begin
        units.insert(units.size(), LowFirst | 16'($urandom_range(10'h3FF)));
      end else if (pick < 97) begin
        units.insert(units.size(), 16'h0000);
      end else begin
        case ($urandom_range(3))
          0: units.insert(units.size(), 16'h0001);
          1: units.insert(units.size(), 16'hD7FF);
          2: units.insert(units.size(), 16'hE000);
          default: units.insert(units.size(), 16'hFFFF);
        endcase
      end
    end
    foreach (units[i]) begin
      it.code_unit = units[i];
      it.last_unit = (i == units.size() - 1);
      if (!string_stopped) units_counted++;
      send_unit(it, Derived, 3'd0, 48'h0);
    end
  endtask

  // Drive ready at the falling edge; a requested hold keeps it low for a long stretch
  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        dn_ready <= 1'b0;
      end else begin
        dn_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare every accepted output item with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && dn_valid && dn_ready) begin
      results_checked++;
      if (dn_item.no_byte) markers_seen++;
      if (expected_bytes.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("%0t: unexpected item byte=%h run_last=%b string_end=%b no_byte=%b", $time,
                   dn_item.utf8_byte, dn_item.run_last, dn_item.string_end, dn_item.no_byte);
      end else begin
        want = expected_bytes.pop_front();
        if (dn_item.utf8_byte !== want.utf8_byte || dn_item.run_last !== want.run_last ||
            dn_item.string_end !== want.string_end || dn_item.no_byte !== want.no_byte) begin
          failures++;
          if (failures <= ReportLimit)
            $display("%0t: mismatch byte=%h/%h run_last=%b/%b string_end=%b/%b no_byte=%b/%b",
                     $time, dn_item.utf8_byte, want.utf8_byte, dn_item.run_last, want.run_last,
                     dn_item.string_end, want.string_end, dn_item.no_byte, want.no_byte);
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    in_item_t    it;
    int unsigned waited;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows, no idling
    for (int unsigned r = 0; r < DirCount; r++) begin
      it.code_unit = DirRows[r].unit;
      it.last_unit = DirRows[r].last;
      send_unit(it, DirRows[r].typed, DirRows[r].count, DirRows[r].bytes);
    end

    // Random strings: free run with one long receiver hold, then the idling mixes
    hold_requests++;
    while (units_counted < PhaseUnits) send_random_string();
    send_idle_pct = 75;
    while (units_counted < 2 * PhaseUnits) send_random_string();
    send_idle_pct = 0;
    stall_pct = 75;
    while (units_counted < 3 * PhaseUnits) send_random_string();
    send_idle_pct = 25;
    stall_pct = 25;
    while (units_counted < 4 * PhaseUnits) send_random_string();
    send_idle_pct = 0;
    stall_pct = 0;
    up_valid <= 1'b0;

    // Drain, then let any stray output show up
    waited = 0;
    while (expected_bytes.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      failures++;
      $display("%0d expected items never arrived", expected_bytes.size());
    end

    $display("Sent %0d UTF-16 units (%0d random), checked %0d output items, %0d end markers.",
             units_sent, units_counted, results_checked, markers_seen);
    $display("Idling mixes: none, sender 75%%, receiver 75%%, both 25%%; %0d failures.",
             failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/utf_pkg.sv
rtl/utf_front.sv
rtl/utf_queue.sv
rtl/utf_back.sv
rtl/utf16_to_utf8_transcoder.sv
rtl/utf_checker.sv
test/tb.sv
